// ----- src/lte_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lte_pkg
// Shared types and constants for the list transform engine.
// ----------------------------------------------------------------------------
package lte_pkg;

    localparam int DEFAULT_LIST_DEPTH = 64;
    localparam int VALUE_W            = 32;
    localparam int OP_W               = 3;

    typedef enum logic [OP_W-1:0] {
        OP_DROP_FIRST  = 3'd0,
        OP_DROP_LAST   = 3'd1,
        OP_LAST_FRONT  = 3'd2,
        OP_FIRST_BACK  = 3'd3,
        OP_REVERSE     = 3'd4,
        OP_SORT        = 3'd5,
        OP_DEDUP       = 3'd6,
        OP_PASS        = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_FETCH,
        ST_SORT_TAKE,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_DD_FETCH,
        ST_DD_TAKE,
        ST_DD_RD,
        ST_DD_CMP,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

endpackage
`default_nettype wire

// ----- src/list_transform_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// list_transform_engine
// Stores a list, applies the configured transform, streams the result.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle into the list memory while the engine is
// loading; elements beyond LIST_DEPTH are dropped and every result of that
// list carries overflow. The transaction marked last closes the list and the
// operation in effect at that edge is applied; in_stall then stays high until
// the last result has been loaded into the output register. Sort (insertion)
// and dedup (keep first occurrence) run through one shared compare unit on
// the single read port of the memory: each element is fetched and taken,
// then each compare step reads a memory word and compares, and the element
// is placed or, as a duplicate, dropped. The drops, rotations and reverse
// cost nothing extra as they are address remaps at readout. Each result is
// read and loaded into the output register once the receiver does not
// stall; an empty result list still gives one result, result_present low.
module list_transform_engine #(
    parameter int LIST_DEPTH = lte_pkg::DEFAULT_LIST_DEPTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [lte_pkg::OP_W-1:0]    cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [31:0]          element_value,
    input  wire logic                        has_element,
    input  wire logic                        last_element,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [31:0]               result_value,
    output logic                             result_present,
    output logic                             result_last,
    output logic                             overflow
);
    import lte_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [VALUE_W-1:0] mem [LIST_DEPTH];

    state_t           state_reg, state_next;
    op_t              op_reg;
    op_t              run_op_reg, run_op_next; // operation of the list in flight
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [CW-1:0]    i_reg, i_next;     // outer index
    logic [CW-1:0]    j_reg, j_next;     // inner index
    logic [CW-1:0]    kept_reg, kept_next;
    logic [VALUE_W-1:0] t_reg, t_next;   // held element
    logic [VALUE_W-1:0] rd_reg;
    logic               oval_reg, oval_next;
    logic [VALUE_W-1:0] oval_data_reg, oval_data_next;
    logic               opres_reg, opres_next;
    logic               olast_reg, olast_next;
    logic               oovf_reg, oovf_next;

    // memory port controls
    logic             we;
    logic [AW-1:0]    waddr;
    logic [VALUE_W-1:0] wdata;
    logic [AW-1:0]    raddr;

    logic             in_acc;
    logic             list_close;
    logic             store_ok;
    logic [CW-1:0]    cnt_after;    // count once the current element is stored
    logic [CW-1:0]    n_out;        // result length
    logic [CW-1:0]    src_idx;      // readout address before truncation
    logic [CW-1:0]    i_inc;
    logic [CW-1:0]    i_adv;        // next outer index, wraps to 0 for readout
    logic [CW-1:0]    j_dec;
    logic             pass_done;
    logic             emit_last;
    logic             t_less;
    logic             t_equal;

    assign cfg_ready  = (state_reg == ST_LOAD) && !oval_reg;
    assign in_stall   = (state_reg != ST_LOAD);
    assign in_acc     = in_valid && !in_stall;
    assign list_close = in_acc && last_element;
    assign store_ok   = has_element && (cnt_reg < CW'(LIST_DEPTH));
    assign cnt_after  = store_ok ? cnt_reg + CW'(1) : cnt_reg;
    assign i_inc      = i_reg + CW'(1);
    assign pass_done  = (i_inc >= cnt_reg);
    assign i_adv      = pass_done ? '0 : i_inc;
    assign j_dec      = j_reg - CW'(1);
    assign emit_last  = (n_out == '0) || (i_inc >= n_out);

    // shared compare unit: held element against memory read data
    assign t_less  = $signed(t_reg) < $signed(rd_reg);
    assign t_equal = (t_reg == rd_reg);

    // result length by operation
    always_comb
    begin
        case (run_op_reg)
            OP_DROP_FIRST, OP_DROP_LAST: n_out = (cnt_reg <= CW'(1)) ? '0 : cnt_reg - CW'(1);
            OP_DEDUP:                    n_out = (cnt_reg <= CW'(1)) ? cnt_reg : kept_reg;
            default:                     n_out = cnt_reg;
        endcase
    end

    // readout address remap
    always_comb
    begin
        src_idx = i_reg;
        if (cnt_reg > CW'(1))
        begin
            case (run_op_reg)
                OP_DROP_FIRST: src_idx = i_reg + CW'(1);
                OP_LAST_FRONT: src_idx = (i_reg == '0) ? cnt_reg - CW'(1) : i_reg - CW'(1);
                OP_FIRST_BACK: src_idx = (i_reg == cnt_reg - CW'(1)) ? '0 : i_reg + CW'(1);
                OP_REVERSE:    src_idx = cnt_reg - CW'(1) - i_reg;
                default:       src_idx = i_reg;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
                if (list_close)
                begin
                    if (op_reg == OP_SORT && cnt_after > CW'(1))
                        state_next = ST_SORT_FETCH;
                    else if (op_reg == OP_DEDUP && cnt_after > CW'(1))
                        state_next = ST_DD_FETCH;
                    else
                        state_next = ST_EMIT_RD;
                end
            ST_SORT_FETCH: state_next = ST_SORT_TAKE;
            ST_SORT_TAKE:  state_next = ST_SORT_RD;
            ST_SORT_RD:
                if (j_reg == '0)
                    state_next = pass_done ? ST_EMIT_RD : ST_SORT_FETCH;
                else
                    state_next = ST_SORT_CMP;
            ST_SORT_CMP:
                if (t_less)
                    state_next = ST_SORT_RD;
                else
                    state_next = pass_done ? ST_EMIT_RD : ST_SORT_FETCH;
            ST_DD_FETCH:   state_next = ST_DD_TAKE;
            ST_DD_TAKE:    state_next = ST_DD_RD;
            ST_DD_RD:
                if (j_reg >= kept_reg)
                    state_next = pass_done ? ST_EMIT_RD : ST_DD_FETCH;
                else
                    state_next = ST_DD_CMP;
            ST_DD_CMP:
                if (t_equal)
                    state_next = pass_done ? ST_EMIT_RD : ST_DD_FETCH;
                else
                    state_next = ST_DD_RD;
            ST_EMIT_RD:
                if (!oval_reg || !out_stall)
                    state_next = ST_EMIT_OUT;
            ST_EMIT_OUT:   state_next = emit_last ? ST_LOAD : ST_EMIT_RD;
            default:       state_next = ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        run_op_next    = run_op_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        kept_next      = kept_reg;
        t_next         = t_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = t_reg;
        raddr          = '0;
        oval_next      = oval_reg && out_stall;
        oval_data_next = oval_data_reg;
        opres_next     = opres_reg;
        olast_next     = olast_reg;
        oovf_next      = oovf_reg;
        case (state_reg)
            ST_LOAD:
                if (in_acc)
                begin
                    if (store_ok)
                    begin
                        we    = 1'b1;
                        waddr = cnt_reg[AW-1:0];
                        wdata = element_value;
                    end
                    else if (has_element)
                        ovf_next = 1'b1;
                    cnt_next = cnt_after;
                    if (last_element)
                    begin
                        // sort and dedup start at element 1 with element 0 kept
                        run_op_next = op_reg;
                        kept_next   = CW'(1);
                        if ((op_reg == OP_SORT || op_reg == OP_DEDUP) && cnt_after > CW'(1))
                            i_next = CW'(1);
                        else
                            i_next = '0;
                    end
                end
            ST_SORT_FETCH, ST_DD_FETCH:
                raddr = i_reg[AW-1:0];
            ST_SORT_TAKE:
            begin
                t_next = rd_reg;
                j_next = i_reg;
            end
            ST_SORT_RD:
                if (j_reg == '0)
                begin
                    // reached the front: place the held element there
                    we     = 1'b1;
                    waddr  = '0;
                    i_next = i_adv;
                end
                else
                    raddr = j_dec[AW-1:0];
            ST_SORT_CMP:
                if (t_less)
                begin
                    // shift the larger element up one slot
                    we     = 1'b1;
                    waddr  = j_reg[AW-1:0];
                    wdata  = rd_reg;
                    j_next = j_dec;
                end
                else
                begin
                    we     = 1'b1;
                    waddr  = j_reg[AW-1:0];
                    i_next = i_adv;
                end
            ST_DD_TAKE:
            begin
                t_next = rd_reg;
                j_next = '0;
            end
            ST_DD_RD:
                if (j_reg >= kept_reg)
                begin
                    // no match in the kept prefix: append
                    we        = 1'b1;
                    waddr     = kept_reg[AW-1:0];
                    kept_next = kept_reg + CW'(1);
                    i_next    = i_adv;
                end
                else
                    raddr = j_reg[AW-1:0];
            ST_DD_CMP:
                if (t_equal)
                    i_next = i_adv;
                else
                    j_next = j_reg + CW'(1);
            ST_EMIT_RD:
                raddr = src_idx[AW-1:0];
            ST_EMIT_OUT:
            begin
                oval_next      = 1'b1;
                oval_data_next = (n_out == '0) ? '0 : rd_reg;
                opres_next     = (n_out != '0);
                olast_next     = emit_last;
                oovf_next      = ovf_reg;
                i_next         = i_inc;
                if (emit_last)
                begin
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // memory
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            op_reg    <= OP_DROP_FIRST;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            oval_reg  <= oval_next;
            if (cfg_valid && cfg_ready)
                op_reg <= op_t'(cfg_data);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        run_op_reg    <= run_op_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        kept_reg      <= kept_next;
        t_reg         <= t_next;
        oval_data_reg <= oval_data_next;
        opres_reg     <= opres_next;
        olast_reg     <= olast_next;
        oovf_reg      <= oovf_next;
    end

    assign out_valid      = oval_reg;
    assign result_value   = oval_data_reg;
    assign result_present = opres_reg;
    assign result_last    = olast_reg;
    assign overflow       = oovf_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(LIST_DEPTH))
        else $error("element count beyond depth");
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !result_present) |-> result_last)
        else $error("empty result not last");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result_value)
                                      && $stable(result_last)))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// ----- bench/list_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_checker
// Watches the config, input and result channels of the list transform
// engine, keeps its own copy of the list and operation, predicts each result
// list when a list closes and compares every result transaction in order.
// ----------------------------------------------------------------------------
module list_checker #(
    parameter int LIST_DEPTH = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_ready,
    input  wire logic [lte_pkg::OP_W-1:0]  cfg_data,
    input  wire logic                      in_valid,
    input  wire logic                      in_stall,
    input  wire logic signed [31:0]        element_value,
    input  wire logic                      has_element,
    input  wire logic                      last_element,
    input  wire logic                      out_valid,
    input  wire logic                      out_stall,
    input  wire logic signed [31:0]        result_value,
    input  wire logic                      result_present,
    input  wire logic                      result_last,
    input  wire logic                      overflow,
    output int                             fail_count,
    output int                             pending,
    output int                             lists_done,
    output int                             results_seen
);
    import lte_pkg::*;

    localparam int EXP_SLOTS = 256;

    typedef struct packed {
        logic signed [31:0] value;
        logic               present;
        logic               last;
        logic               ovf;
    } result_t;

    op_t                 cur_op;
    logic signed [31:0]  held [LIST_DEPTH];
    int                  held_n;
    logic                held_ovf;
    result_t             exp_fifo [EXP_SLOTS];   // circular list of expected results
    int                  exp_wr;
    int                  exp_rd;

    // Queue one expected result
    task automatic put_expected(input logic signed [31:0] v, input logic p,
                                input logic l, input logic o);
        result_t r;
        begin
            r.value   = v;
            r.present = p;
            r.last    = l;
            r.ovf     = o;
            exp_fifo[exp_wr % EXP_SLOTS] = r;
            exp_wr++;
        end
    endtask

    // Apply the transform to a closed list and queue its results
    task automatic predict_list();
        logic signed [31:0] w [LIST_DEPTH];
        logic signed [31:0] t;
        int                 n;
        int                 j;
        int                 kept;
        bit                 dup;
        begin
            n = held_n;
            for (int i = 0; i < n; i++)
                w[i] = held[i];
            if (cur_op == OP_DROP_FIRST || cur_op == OP_DROP_LAST)
            begin
                if (n <= 1)
                    n = 0;
                else
                begin
                    if (cur_op == OP_DROP_FIRST)
                        for (int i = 0; i + 1 < n; i++)
                            w[i] = w[i + 1];
                    n = n - 1;
                end
            end
            else if (n > 1)
            begin
                case (cur_op)
                    OP_LAST_FRONT:
                    begin
                        t = w[n - 1];
                        for (int i = n - 1; i > 0; i--)
                            w[i] = w[i - 1];
                        w[0] = t;
                    end
                    OP_FIRST_BACK:
                    begin
                        t = w[0];
                        for (int i = 0; i + 1 < n; i++)
                            w[i] = w[i + 1];
                        w[n - 1] = t;
                    end
                    OP_REVERSE:
                        for (int i = 0; i < n / 2; i++)
                        begin
                            t            = w[i];
                            w[i]         = w[n - 1 - i];
                            w[n - 1 - i] = t;
                        end
                    OP_SORT:
                        // stable insertion sort, signed
                        for (int i = 1; i < n; i++)
                        begin
                            t = w[i];
                            j = i;
                            while (j > 0 && t < w[j - 1])
                            begin
                                w[j] = w[j - 1];
                                j--;
                            end
                            w[j] = t;
                        end
                    OP_DEDUP:
                    begin
                        kept = 0;
                        for (int i = 0; i < n; i++)
                        begin
                            dup = 0;
                            for (int k = 0; k < kept; k++)
                                if (w[k] == w[i])
                                    dup = 1;
                            if (!dup)
                            begin
                                w[kept] = w[i];
                                kept++;
                            end
                        end
                        n = kept;
                    end
                    default: ;
                endcase
            end
            if (n == 0)
                put_expected('0, 1'b0, 1'b1, held_ovf);
            else
                for (int i = 0; i < n; i++)
                    put_expected(w[i], 1'b1, (i == n - 1), held_ovf);
            held_n   = 0;
            held_ovf = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            cur_op       = OP_DROP_FIRST;
            held_n       = 0;
            held_ovf     = 0;
            exp_wr       = 0;
            exp_rd       = 0;
            pending      = 0;
            fail_count   = 0;
            lists_done   = 0;
            results_seen = 0;
        end
        else
        begin
            // result side first: a list closing now cannot emit this cycle
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (exp_wr == exp_rd)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%t: unexpected result value=%0d", $realtime,
                                 result_value);
                end
                else
                begin
                    exp_r = exp_fifo[exp_rd % EXP_SLOTS];
                    exp_rd++;
                    if (result_value !== exp_r.value || result_present !== exp_r.present
                        || result_last !== exp_r.last || overflow !== exp_r.ovf)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%t: mismatch exp v=%0d p=%0b l=%0b o=%0b",
                                      " got v=%0d p=%0b l=%0b o=%0b"},
                                     $realtime, exp_r.value, exp_r.present, exp_r.last,
                                     exp_r.ovf, result_value, result_present,
                                     result_last, overflow);
                    end
                end
            end
            // a list closing together with a register write uses the old operation
            if (in_valid && !in_stall)
            begin
                if (has_element)
                begin
                    if (held_n < LIST_DEPTH)
                    begin
                        held[held_n] = element_value;
                        held_n++;
                    end
                    else
                        held_ovf = 1;
                end
                if (last_element)
                begin
                    predict_list();
                    lists_done++;
                end
            end
            if (cfg_valid && cfg_ready)
                cur_op = op_t'(cfg_data);
            pending = exp_wr - exp_rd;
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the list transform engine: directed lists for each operation
// and the size edge cases, then random lists under several operations, with
// bursty input, patterned output stalls and a long stall to fill the engine.
// ----------------------------------------------------------------------------
module tb_top;
    import lte_pkg::*;

    localparam int DEPTH = 64;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [OP_W-1:0]    cfg_data = '0;
    logic               in_valid = 0;
    logic               in_stall;
    logic signed [31:0] element_value = '0;
    logic               has_element = 0;
    logic               last_element = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic signed [31:0] result_value;
    logic               result_present;
    logic               result_last;
    logic               overflow;
    int                 fail_count, pending, lists_done, results_seen;
    int                 items_sent;
    int                 burst_left;
    bit                 hold_off_req;
    bit                 stim_done;

    always #5 clk = ~clk;

    list_transform_engine #(.LIST_DEPTH(DEPTH)) i_dut (.*);

    list_checker #(.LIST_DEPTH(DEPTH)) i_checker (.*);

    // Receiver: stalls on a phase-shifting pattern, or holds off on request
    initial
    begin
        int phase;
        int hold;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req <= 0;
                out_stall <= 1;
                for (hold = 0; hold < 600; hold++)
                    @(posedge clk);
                out_stall <= 0;
            end
            else
            begin
                phase++;
                if (phase % 400 < 100)
                    out_stall <= 0;
                else
                    out_stall <= ((phase % 7) < 2) || ($urandom_range(0, 9) == 0);
            end
        end
    end

    // One input transaction; a random gap opens each new burst
    task automatic send_item(input logic signed [31:0] v, input logic he, input logic le);
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            in_valid      <= 1'b1;
            element_value <= v;
            has_element   <= he;
            last_element  <= le;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            items_sent++;
            burst_left--;
        end
    endtask

    task automatic drain_and_set_op(input op_t op);
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
            repeat (20) @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= op;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 7) - 4;
            1:       return 32'sh8000_0000 + $urandom_range(0, 2);
            2:       return 32'sh7fff_ffff - $urandom_range(0, 2);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_list(input int n, input bit empty_end);
        logic signed [31:0] v;
        begin
            for (int i = 0; i < n; i++)
            begin
                v = rand_value();
                if (!empty_end && i == n - 1)
                    send_item(v, 1'b1, 1'b1);
                else
                begin
                    send_item(v, 1'b1, 1'b0);
                    if ($urandom_range(0, 15) == 0)
                        send_item($urandom, 1'b0, 1'b0);
                end
            end
            if (empty_end)
                send_item($urandom, 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        int n;
        items_sent   = 0;
        burst_left   = 0;
        hold_off_req = 0;
        stim_done    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset operation (drop first) on edge sizes, then each op
        send_item(32'sh7fff_ffff, 1'b0, 1'b1);          // empty list
        send_item(32'sh8000_0000, 1'b1, 1'b1);          // single element
        send_item(32'sh8000_0000, 1'b1, 1'b0);
        send_item(32'sh7fff_ffff, 1'b1, 1'b1);
        for (int o = 0; o < 8; o++)
        begin
            drain_and_set_op(op_t'(o));
            send_item(32'sh8000_0000, 1'b1, 1'b0);
            send_item(32'sh7fff_ffff, 1'b1, 1'b0);
            send_item(-1, 1'b1, 1'b0);
            send_item(32'sh7fff_ffff, 1'b1, 1'b1);
        end
        // Overflow: drop-last on a list longer than the store, receiver held off
        drain_and_set_op(OP_DROP_LAST);
        hold_off_req = 1;
        send_list(DEPTH + 3, 1'b1);
        send_item(5, 1'b1, 1'b1);                       // single element, op 1
        drain_and_set_op(OP_REVERSE);
        send_item(9, 1'b1, 1'b1);                       // single element, unchanged
        send_item(0, 1'b0, 1'b1);                       // empty, non-drop op

        // Random: small lists, a few large, op changes between phases
        while (items_sent < 340)
        begin
            drain_and_set_op(op_t'($urandom_range(0, 7)));
            if ($urandom_range(0, 2) == 0)
                hold_off_req = 1;
            for (int l = 0; l < 6; l++)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 68)
                                                : $urandom_range(0, 8);
                send_list(n, (n == 0) || ($urandom_range(0, 4) == 0));
            end
        end
        drain_and_set_op(OP_SORT);
        hold_off_req = 1;
        send_list(DEPTH, 1'b0);
        send_list(5, 1'b0);
        in_valid <= 1'b0;
        stim_done = 1;
    end

    // Verdict
    initial
    begin
        @(posedge stim_done);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d input items in %0d lists; checked %0d results.",
                 items_sent, lists_done, results_seen);
        $display("Covered all operations, empty and single lists, overflow and long stalls.");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
